// ===== sv/ttx_pkg.sv =====
`default_nettype none

package ttx_pkg;

    // Screen geometry
    localparam int COLUMNS = 40;
    localparam int ROWS    = 25;

    localparam logic [5:0] LAST_COLUMN = 6'(COLUMNS - 1);
    localparam logic [4:0] LAST_ROW    = 5'(ROWS - 1);

    // Control codes
    localparam logic [7:0] CODE_COLOUR_FIRST = 8'd128;
    localparam logic [7:0] CODE_COLOUR_LAST  = 8'd135;
    localparam logic [7:0] CODE_NORMAL_SIZE  = 8'd140;
    localparam logic [7:0] CODE_DOUBLE_SIZE  = 8'd141;
    localparam logic [7:0] CODE_BLACK_BACK   = 8'd156;
    localparam logic [7:0] CODE_NEW_BACK     = 8'd157;
    localparam logic [7:0] CODE_SPACE        = 8'h20;

    localparam logic [2:0] COLOUR_BLACK = 3'd0;
    localparam logic [2:0] COLOUR_WHITE = 3'd7;

    // Position of the cell being decoded, from the counter block
    typedef struct packed {
        logic [5:0]  column;
        logic [4:0]  row;
        logic [14:0] cell_address;
        logic        row_start;
        logic        frame_start;
    } pos_t;

    // Attributes of the cell after its code is applied
    typedef struct packed {
        logic [6:0] glyph_index;
        logic [2:0] fore_colour;
        logic [2:0] back_colour;
        logic       double_height;
        logic       lower_half;
    } attr_t;

    // Bit 11 of the linear address moves to bit 14; bits 13..10 are forced high
    function automatic logic [14:0] map_address(input logic [15:0] lin);
        return {lin[11], 4'hF, lin[9:0]};
    endfunction

endpackage

`default_nettype wire

// ===== sv/ttx_if.sv =====
`default_nettype none

interface ttx_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;

    modport source (output valid, output char_code, input ready);
    modport sink   (input valid, input char_code, output ready);
endinterface

interface ttx_cell_if;
    logic        valid;
    logic        ready;
    logic [6:0]  glyph_index;
    logic [2:0]  fore_colour;
    logic [2:0]  back_colour;
    logic        double_height;
    logic        lower_half;
    logic [14:0] cell_address;
    logic [5:0]  column;
    logic [4:0]  row;

    modport source (output valid, output glyph_index, output fore_colour,
                    output back_colour, output double_height, output lower_half,
                    output cell_address, output column, output row, input ready);
    modport sink   (input valid, input glyph_index, input fore_colour,
                    input back_colour, input double_height, input lower_half,
                    input cell_address, input column, input row, output ready);
endinterface

`default_nettype wire

// ===== sv/ttx_position.sv =====
`default_nettype none

module ttx_position
    import ttx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [13:0] start_address,
    output pos_t             pos
);

    logic [5:0]  col_reg,    col_next;
    logic [4:0]  row_reg,    row_next;
    logic [15:0] offset_reg, offset_next;
    logic [15:0] lin;
    logic        frame_start;

    assign frame_start = (col_reg == '0) && (row_reg == '0);
    assign lin         = frame_start ? {2'b00, start_address} : offset_reg;

    always_comb
    begin
        offset_next = lin + 16'd1;
        col_next    = col_reg + 6'd1;
        row_next    = row_reg;
        if (col_reg == LAST_COLUMN)
        begin
            col_next = '0;
            row_next = (row_reg == LAST_ROW) ? '0 : row_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            offset_reg <= '0;
        end
        else if (step)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            offset_reg <= offset_next;
        end
    end

    assign pos.column       = col_reg;
    assign pos.row          = row_reg;
    assign pos.cell_address = map_address(lin);
    assign pos.row_start    = (col_reg == '0);
    assign pos.frame_start  = frame_start;

endmodule

`default_nettype wire

// ===== sv/ttx_attr.sv =====
`default_nettype none

module ttx_attr
    import ttx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] char_code,
    input  pos_t            pos,
    output attr_t           attr
);

    logic [2:0] fore_reg,    fore_next;
    logic [2:0] back_reg,    back_next;
    logic       pending_reg, pending_next;
    logic       double_reg,  double_next;
    logic       second_reg,  second_next;

    always_comb
    begin
        // Row start: back to white on black, settle the lower-half row flag
        fore_next    = pos.row_start ? COLOUR_WHITE : fore_reg;
        back_next    = pos.row_start ? COLOUR_BLACK : back_reg;
        pending_next = pos.row_start ? 1'b0 : pending_reg;
        double_next  = pos.row_start ? 1'b0 : double_reg;
        second_next  = second_reg;
        if (pos.row_start)
            second_next = pos.frame_start ? 1'b0 : (double_reg && !second_reg);

        if (char_code >= CODE_COLOUR_FIRST && char_code <= CODE_COLOUR_LAST)
        begin
            if (pending_next)
            begin
                back_next    = char_code[2:0];
                pending_next = 1'b0;
            end
            else
                fore_next = char_code[2:0];
        end
        else
        begin
            case (char_code)
                CODE_NORMAL_SIZE: double_next  = 1'b0;
                CODE_DOUBLE_SIZE: double_next  = 1'b1;
                CODE_BLACK_BACK:  back_next    = COLOUR_BLACK;
                CODE_NEW_BACK:    pending_next = 1'b1;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg    <= COLOUR_WHITE;
            back_reg    <= COLOUR_BLACK;
            pending_reg <= 1'b0;
            double_reg  <= 1'b0;
            second_reg  <= 1'b0;
        end
        else if (step)
        begin
            fore_reg    <= fore_next;
            back_reg    <= back_next;
            pending_reg <= pending_next;
            double_reg  <= double_next;
            second_reg  <= second_next;
        end
    end

    // Printable codes 32..127 map to glyphs 0..95, everything else is a space
    assign attr.glyph_index   = (!char_code[7] && char_code[6:5] != 2'b00)
                                ? 7'(char_code - CODE_SPACE) : 7'd0;
    assign attr.fore_colour   = fore_next;
    assign attr.back_colour   = back_next;
    assign attr.double_height = double_next;
    assign attr.lower_half    = second_next;

endmodule

`default_nettype wire

// ===== sv/teletext_attribute_decoder.sv =====
`default_nettype none

// Teletext attribute decoder. Takes one character byte per screen cell on
// char_in and returns one decoded cell on cell_out: glyph index, foreground
// and background colour, double-height and lower-half flags, the mapped
// screen memory address and the cell's column and row. Column and row are
// counted internally (40 cells per row, 25 rows per frame) from reset, so
// the first transaction after reset is column 0 of row 0. A transaction
// passes through two registers, the input register and then the result
// register, and is offered on cell_out from the result register. The
// decoder accepts a new transaction in every cycle while cell_out is taken;
// a stall on cell_out holds the pipeline, and the input register can
// still take one more transaction before char_in stalls. start_address
// is loaded through cfg_wr_en/cfg_wr_data and is picked up at the first
// cell of each frame; write it only while no transaction is in flight.

module teletext_attribute_decoder
    import ttx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [13:0] cfg_wr_data,
    ttx_char_if.sink         char_in,
    ttx_cell_if.source       cell_out
);

    logic [13:0] start_address_reg;
    logic        in_valid_reg;
    logic [7:0]  in_code_reg;
    logic        out_valid_reg;
    pos_t        out_pos_reg;
    attr_t       out_attr_reg;

    logic        advance;
    logic        step;
    pos_t        pos;
    attr_t       attr;

    // Advance whenever the result register is free or being emptied
    assign advance       = !out_valid_reg || cell_out.ready;
    assign step          = in_valid_reg && advance;
    assign char_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_address_reg <= '0;
        else if (cfg_wr_en)
            start_address_reg <= cfg_wr_data;
    end

    // Input register: hold the code until the decode stage takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (char_in.ready)
            in_valid_reg <= char_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
            in_code_reg <= char_in.char_code;
    end

    ttx_position u_position (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .start_address (start_address_reg),
        .pos           (pos)
    );

    ttx_attr u_attr (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_code (in_code_reg),
        .pos       (pos),
        .attr      (attr)
    );

    // Result register: drop the valid once taken, load on every decode step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_pos_reg  <= pos;
            out_attr_reg <= attr;
        end
    end

    assign cell_out.valid         = out_valid_reg;
    assign cell_out.glyph_index   = out_attr_reg.glyph_index;
    assign cell_out.fore_colour   = out_attr_reg.fore_colour;
    assign cell_out.back_colour   = out_attr_reg.back_colour;
    assign cell_out.double_height = out_attr_reg.double_height;
    assign cell_out.lower_half    = out_attr_reg.lower_half;
    assign cell_out.cell_address  = out_pos_reg.cell_address;
    assign cell_out.column        = out_pos_reg.column;
    assign cell_out.row           = out_pos_reg.row;

endmodule

`default_nettype wire
